// ===== rtl/bfknn_pkg.sv =====
package bfknn_pkg;

    localparam int CAPACITY_DEF     = 256;
    localparam int MAX_DIM_DEF      = 16;
    localparam int MAX_K_DEF        = 16;
    localparam int ELEMENT_BITS_DEF = 16;

    localparam int KEY_W    = 32;
    localparam int DIST_W   = 36;
    localparam int STATUS_W = 3;
    localparam int DIM_W    = 5;
    localparam int TOPK_W   = 5;
    localparam int OP_W     = 2;
    // wide enough for counts up to the largest MAX_DIM and MAX_K plus one
    localparam int CMP_W    = 8;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_KEY_EXIST = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_LEN_ERR   = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NO_RESULT = 3'd5;

    typedef struct packed {
        logic clear;
        logic ins;
        logic pop;
    } cell_ctl_t;

endpackage

// ===== rtl/bfknn_ram.sv =====
module bfknn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/bfknn_cell.sv =====
module bfknn_cell #(
    parameter int SLOT_W = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bfknn_pkg::cell_ctl_t            ctl,
    input  logic [bfknn_pkg::DIST_W-1:0]    cand_dist,
    input  logic [SLOT_W-1:0]               cand_slot,
    input  logic                            left_lt,
    input  logic                            left_vld,
    input  logic [bfknn_pkg::DIST_W-1:0]    left_dist,
    input  logic [SLOT_W-1:0]               left_slot,
    input  logic                            right_vld,
    input  logic [bfknn_pkg::DIST_W-1:0]    right_dist,
    input  logic [SLOT_W-1:0]               right_slot,
    output logic                            vld,
    output logic [bfknn_pkg::DIST_W-1:0]    cur_dist,
    output logic [SLOT_W-1:0]               slot,
    output logic                            lt
);
    import bfknn_pkg::*;

    logic              vld_reg, vld_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // equal distance keeps the older (lower) slot in front
    assign lt       = !vld_reg || (cand_dist < dist_reg);
    assign vld      = vld_reg;
    assign cur_dist = dist_reg;
    assign slot     = slot_reg;

    always_comb begin
        vld_next  = vld_reg;
        dist_next = dist_reg;
        slot_next = slot_reg;
        priority if (ctl.clear) begin
            vld_next = 1'b0;
        end else if (ctl.ins && lt) begin
            if (left_lt) begin
                vld_next  = left_vld;
                dist_next = left_dist;
                slot_next = left_slot;
            end else begin
                vld_next  = 1'b1;
                dist_next = cand_dist;
                slot_next = cand_slot;
            end
        end else if (ctl.pop) begin
            vld_next  = right_vld;
            dist_next = right_dist;
            slot_next = right_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        dist_reg <= dist_next;
        slot_reg <= slot_next;
    end
endmodule

// ===== rtl/brute_force_knn_index_top.sv =====
// channel  dir  tdata (low bit up)                        tuser       tlast
// s_       in   key[32], element_value[EB], top_k[5]     operation   last_element
// m_       out  status[3], result_key[32], distance[36],  -           last_result
//               result_element[EB]
// cfg_     in   cfg_wdata = dimension[5], written when cfg_we is high
// Element items of add and search are buffered without leaving the idle state.
// Add, remove and get scan the key memory (S_SC_RD, S_SC_END, S_SC_DEC), then an add
// writes MAX_DIM vector words and a get gives one element per S_GT_RD, S_GT_WAIT pass.
// A search scans every slot, reading dimension words of each valid slot through the
// vector memory read port, then gives one hit per S_SO_RD, S_SO_WAIT pass.
// Reset is synchronous; no clearing pass. Input stalls while an item is in work
// or a result waits in the output register.
module brute_force_knn_index_top #(
    parameter int CAPACITY     = bfknn_pkg::CAPACITY_DEF,
    parameter int MAX_DIM      = bfknn_pkg::MAX_DIM_DEF,
    parameter int MAX_K        = bfknn_pkg::MAX_K_DEF,
    parameter int ELEMENT_BITS = bfknn_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          cfg_we,
    input  logic [bfknn_pkg::DIM_W-1:0]                   cfg_wdata,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // key, element_value, top_k
    input  logic [((37 + ELEMENT_BITS + 7) / 8) * 8-1:0]  s_tdata,
    // operation
    input  logic [bfknn_pkg::OP_W-1:0]                    s_tuser,
    input  logic                                          s_tlast,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // status, result_key, distance, result_element
    output logic [((71 + ELEMENT_BITS + 7) / 8) * 8-1:0]  m_tdata,
    output logic                                          m_tlast
);
    import bfknn_pkg::*;

    localparam int EB      = ELEMENT_BITS;
    localparam int IN_TW   = ((37 + EB + 7) / 8) * 8;
    localparam int OUT_TW  = ((71 + EB + 7) / 8) * 8;
    localparam int SLOT_W  = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
    localparam int SCNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W   = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W   = $clog2(MAX_DIM + 2);
    localparam int KW      = $clog2(MAX_K + 1);
    localparam int VDEPTH  = CAPACITY * MAX_DIM;
    localparam int VADDR_W = VDEPTH > 1 ? $clog2(VDEPTH) : 1;
    localparam int SQ_W    = 2 * (EB + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SC_RD    = 4'd1;
    localparam logic [3:0] S_SC_END   = 4'd2;
    localparam logic [3:0] S_SC_DEC   = 4'd3;
    localparam logic [3:0] S_AD_WR    = 4'd4;
    localparam logic [3:0] S_GT_RD    = 4'd5;
    localparam logic [3:0] S_GT_WAIT  = 4'd6;
    localparam logic [3:0] S_SR_SLOT  = 4'd7;
    localparam logic [3:0] S_SR_RD    = 4'd8;
    localparam logic [3:0] S_SR_DRAIN = 4'd9;
    localparam logic [3:0] S_SR_FIN   = 4'd10;
    localparam logic [3:0] S_SO_RD    = 4'd11;
    localparam logic [3:0] S_SO_WAIT  = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [DIM_W-1:0]    dimension_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [EB-1:0]       buf_reg [MAX_DIM];
    logic [EB-1:0]       buf_next [MAX_DIM];
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KW-1:0]       topk_reg, topk_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [SCNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic                scan_v_reg, scan_v_next;
    logic [SLOT_W-1:0]   scan_d_reg, scan_d_next;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   found_slot_reg, found_slot_next;
    logic                free_f_reg, free_f_next;
    logic [SLOT_W-1:0]   free_slot_reg, free_slot_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [VADDR_W-1:0]  base_reg, base_next;
    logic [EB-1:0]       q_reg, q_next;
    logic                rd_v_reg, rd_v_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic                sq_v_reg, sq_v_next;
    logic [DIST_W-1:0]   acc_reg, acc_next;
    logic [KW-1:0]       fill_reg, fill_next;
    logic [KW-1:0]       rem_reg, rem_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [KEY_W-1:0]    m_key_reg, m_key_next;
    logic [DIST_W-1:0]   m_dist_reg, m_dist_next;
    logic [EB-1:0]       m_elem_reg, m_elem_next;
    logic                m_last_reg, m_last_next;

    logic                kwe;
    logic [SLOT_W-1:0]   kraddr;
    logic [KEY_W-1:0]    krdata;
    logic                vwe;
    logic [VADDR_W-1:0]  vwaddr, vraddr;
    logic [EB-1:0]       vwdata, vrdata;

    cell_ctl_t           ctl;
    logic                cvld  [MAX_K];
    logic [DIST_W-1:0]   cdist [MAX_K];
    logic [SLOT_W-1:0]   cslot [MAX_K];
    logic                clt   [MAX_K];

    logic [KEY_W-1:0]    in_key;
    logic [EB-1:0]       in_elem;
    logic [TOPK_W-1:0]   in_topk;
    logic                dim_ok;
    logic                out_free;
    logic signed [EB:0]  diff;
    logic signed [SQ_W-1:0] prod;
    logic [DIST_W-1:0]   sq36;
    logic                sq_big;
    logic [DIST_W:0]     sum;
    logic [CNT_W-1:0]    n_val;

    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_elem  = s_tdata[KEY_W +: EB];
    assign in_topk  = s_tdata[KEY_W + EB +: TOPK_W];
    assign dim_ok   = (dimension_reg != '0) && (CMP_W'(dimension_reg) <= CMP_W'(MAX_DIM));
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && !m_tvalid_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_TW'({m_elem_reg, m_dist_reg, m_key_reg, m_status_reg});

    assign diff   = $signed({q_reg[EB-1], q_reg}) - $signed({vrdata[EB-1], vrdata});
    assign prod   = diff * diff;
    assign sq36   = DIST_W'(sq_reg);
    assign sq_big = (SQ_W > DIST_W) ? ((sq_reg >> DIST_W) != '0) : 1'b0;
    assign sum    = {1'b0, acc_reg} + {1'b0, sq36};
    assign n_val  = (CMP_W'(count_reg) <= CMP_W'(MAX_DIM)) ? count_reg + 1'b1 : count_reg;

    bfknn_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .aclk  (aclk),
        .we    (kwe),
        .waddr (free_slot_reg),
        .wdata (key_reg),
        .raddr (kraddr),
        .rdata (krdata)
    );

    bfknn_ram #(.WIDTH(EB), .DEPTH(VDEPTH)) u_vec_ram (
        .aclk  (aclk),
        .we    (vwe),
        .waddr (vwaddr),
        .wdata (vwdata),
        .raddr (vraddr),
        .rdata (vrdata)
    );

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        logic              l_lt, l_vld, r_vld;
        logic [DIST_W-1:0] l_dist, r_dist;
        logic [SLOT_W-1:0] l_slot, r_slot;
        if (g == 0) begin : g_first
            assign l_lt   = 1'b0;
            assign l_vld  = 1'b0;
            assign l_dist = '0;
            assign l_slot = '0;
        end else begin : g_mid
            assign l_lt   = clt[g-1];
            assign l_vld  = cvld[g-1];
            assign l_dist = cdist[g-1];
            assign l_slot = cslot[g-1];
        end
        if (g == MAX_K - 1) begin : g_last
            assign r_vld  = 1'b0;
            assign r_dist = '0;
            assign r_slot = '0;
        end else begin : g_inner
            assign r_vld  = cvld[g+1];
            assign r_dist = cdist[g+1];
            assign r_slot = cslot[g+1];
        end
        bfknn_cell #(.SLOT_W(SLOT_W)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .cand_dist  (acc_reg),
            .cand_slot  (scan_cnt_reg[SLOT_W-1:0]),
            .left_lt    (l_lt),
            .left_vld   (l_vld),
            .left_dist  (l_dist),
            .left_slot  (l_slot),
            .right_vld  (r_vld),
            .right_dist (r_dist),
            .right_slot (r_slot),
            .vld        (cvld[g]),
            .cur_dist   (cdist[g]),
            .slot       (cslot[g]),
            .lt         (clt[g])
        );
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        buf_next        = buf_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        topk_next       = topk_reg;
        valid_next      = valid_reg;
        scan_cnt_next   = scan_cnt_reg;
        scan_v_next     = 1'b0;
        scan_d_next     = scan_d_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        free_f_next     = free_f_reg;
        free_slot_next  = free_slot_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        q_next          = q_reg;
        rd_v_next       = 1'b0;
        sq_next         = $unsigned(prod);
        sq_v_next       = rd_v_reg;
        acc_next        = acc_reg;
        fill_next       = fill_reg;
        rem_next        = rem_reg;
        ctl             = '0;
        kwe             = 1'b0;
        kraddr          = cslot[0];
        vwe             = 1'b0;
        vwaddr          = VADDR_W'(free_slot_reg * MAX_DIM) + VADDR_W'(idx_reg);
        vwdata          = (CMP_W'(idx_reg) < CMP_W'(dimension_reg)) ? buf_reg[idx_reg] : '0;
        vraddr          = base_reg + VADDR_W'(idx_reg);
        m_tvalid_next   = m_tready ? 1'b0 : m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_key_next      = m_key_reg;
        m_dist_next     = m_dist_reg;
        m_elem_next     = m_elem_reg;
        m_last_next     = m_last_reg;

        // key compare stage, in the cycle after the key read
        if (scan_v_reg) begin
            if (valid_reg[scan_d_reg] && (krdata == key_reg) && !found_reg) begin
                found_next      = 1'b1;
                found_slot_next = scan_d_reg;
            end
            if (!valid_reg[scan_d_reg] && !free_f_reg) begin
                free_f_next    = 1'b1;
                free_slot_next = scan_d_reg;
            end
        end

        // saturating accumulate
        if (sq_v_reg) begin
            acc_next = (sq_big || sum[DIST_W]) ? DIST_MAX : sum[DIST_W-1:0];
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_next   = s_tuser;
                    key_next  = in_key;
                    topk_next = (CMP_W'(in_topk) > CMP_W'(MAX_K)) ? KW'(MAX_K) : KW'(in_topk);
                    if (s_tuser == OP_REMOVE || s_tuser == OP_GET) begin
                        count_next    = '0;
                        scan_cnt_next = '0;
                        found_next    = 1'b0;
                        free_f_next   = 1'b0;
                        state_next    = S_SC_RD;
                    end else begin
                        if (CMP_W'(count_reg) < CMP_W'(MAX_DIM)) begin
                            buf_next[count_reg[IDX_W-1:0]] = in_elem;
                        end
                        if (!s_tlast) begin
                            count_next = n_val;
                        end else begin
                            count_next = '0;
                            if (!dim_ok || (CMP_W'(n_val) != CMP_W'(dimension_reg))) begin
                                m_tvalid_next = 1'b1;
                                m_status_next = STAT_LEN_ERR;
                                m_key_next    = '0;
                                m_dist_next   = '0;
                                m_elem_next   = '0;
                                m_last_next   = 1'b1;
                            end else if (s_tuser == OP_ADD) begin
                                scan_cnt_next = '0;
                                found_next    = 1'b0;
                                free_f_next   = 1'b0;
                                state_next    = S_SC_RD;
                            end else begin
                                ctl.clear     = 1'b1;
                                fill_next     = '0;
                                scan_cnt_next = '0;
                                base_next     = '0;
                                state_next    = S_SR_SLOT;
                            end
                        end
                    end
                end
            end
            S_SC_RD: begin
                kraddr        = scan_cnt_reg[SLOT_W-1:0];
                scan_v_next   = 1'b1;
                scan_d_next   = scan_cnt_reg[SLOT_W-1:0];
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCNT_W'(CAPACITY - 1)) begin
                    state_next = S_SC_END;
                end
            end
            S_SC_END: begin
                state_next = S_SC_DEC;
            end
            S_SC_DEC: begin
                m_key_next  = '0;
                m_dist_next = '0;
                m_elem_next = '0;
                m_last_next = 1'b1;
                idx_next    = '0;
                state_next  = S_IDLE;
                unique case (op_reg)
                    OP_REMOVE: begin
                        m_tvalid_next = 1'b1;
                        if (found_reg) begin
                            valid_next[found_slot_reg] = 1'b0;
                            m_status_next = STAT_OK;
                        end else begin
                            m_status_next = STAT_NOT_FOUND;
                        end
                    end
                    OP_GET: begin
                        if (!found_reg) begin
                            m_tvalid_next = 1'b1;
                            m_status_next = STAT_NOT_FOUND;
                        end else if (!dim_ok) begin
                            m_tvalid_next = 1'b1;
                            m_status_next = STAT_LEN_ERR;
                        end else begin
                            state_next = S_GT_RD;
                        end
                    end
                    OP_ADD: begin
                        if (found_reg) begin
                            m_tvalid_next = 1'b1;
                            m_status_next = STAT_KEY_EXIST;
                        end else if (!free_f_reg) begin
                            m_tvalid_next = 1'b1;
                            m_status_next = STAT_FULL;
                        end else begin
                            state_next = S_AD_WR;
                        end
                    end
                    OP_SEARCH: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_AD_WR: begin
                vwe = 1'b1;
                if (idx_reg == '0) begin
                    kwe = 1'b1;
                    valid_next[free_slot_reg] = 1'b1;
                end
                if (idx_reg == IDX_W'(MAX_DIM - 1)) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = STAT_OK;
                    m_key_next    = '0;
                    m_dist_next   = '0;
                    m_elem_next   = '0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_GT_RD: begin
                vraddr = VADDR_W'(found_slot_reg * MAX_DIM) + VADDR_W'(idx_reg);
                if (out_free) begin
                    state_next = S_GT_WAIT;
                end
            end
            S_GT_WAIT: begin
                m_tvalid_next = 1'b1;
                m_status_next = STAT_OK;
                m_key_next    = '0;
                m_dist_next   = '0;
                m_elem_next   = vrdata;
                m_last_next   = CMP_W'(idx_reg) == CMP_W'(dimension_reg) - 1'b1;
                if (CMP_W'(idx_reg) == CMP_W'(dimension_reg) - 1'b1) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_GT_RD;
                end
            end
            S_SR_SLOT: begin
                if (scan_cnt_reg == SCNT_W'(CAPACITY)) begin
                    state_next = S_SR_FIN;
                end else if (valid_reg[scan_cnt_reg[SLOT_W-1:0]]) begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = S_SR_RD;
                end else begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    base_next     = base_reg + VADDR_W'(MAX_DIM);
                end
            end
            S_SR_RD: begin
                rd_v_next = 1'b1;
                q_next    = buf_reg[idx_reg];
                if (CMP_W'(idx_reg) == CMP_W'(dimension_reg) - 1'b1) begin
                    state_next = S_SR_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SR_DRAIN: begin
                if (!rd_v_reg && !sq_v_reg) begin
                    ctl.ins = 1'b1;
                    if (CMP_W'(fill_reg) < CMP_W'(MAX_K)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    base_next     = base_reg + VADDR_W'(MAX_DIM);
                    state_next    = S_SR_SLOT;
                end
            end
            S_SR_FIN: begin
                rem_next = (fill_reg < topk_reg) ? fill_reg : topk_reg;
                if (fill_reg == '0 || topk_reg == '0) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = STAT_NO_RESULT;
                    m_key_next    = '0;
                    m_dist_next   = '0;
                    m_elem_next   = '0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    state_next = S_SO_RD;
                end
            end
            S_SO_RD: begin
                if (out_free) begin
                    state_next = S_SO_WAIT;
                end
            end
            S_SO_WAIT: begin
                m_tvalid_next = 1'b1;
                m_status_next = STAT_OK;
                m_key_next    = krdata;
                m_dist_next   = cdist[0];
                m_elem_next   = '0;
                m_last_next   = rem_reg == KW'(1);
                ctl.pop       = 1'b1;
                rem_next      = rem_reg - 1'b1;
                if (rem_reg == KW'(1)) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_SO_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            dimension_reg <= DIM_W'(MAX_DIM % 32);
            count_reg     <= '0;
            valid_reg     <= '0;
            scan_v_reg    <= 1'b0;
            rd_v_reg      <= 1'b0;
            sq_v_reg      <= 1'b0;
            fill_reg      <= '0;
            rem_reg       <= '0;
            found_reg     <= 1'b0;
            free_f_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                dimension_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            scan_v_reg    <= scan_v_next;
            rd_v_reg      <= rd_v_next;
            sq_v_reg      <= sq_v_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            found_reg     <= found_next;
            free_f_reg    <= free_f_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        buf_reg        <= buf_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        topk_reg       <= topk_next;
        scan_cnt_reg   <= scan_cnt_next;
        scan_d_reg     <= scan_d_next;
        found_slot_reg <= found_slot_next;
        free_slot_reg  <= free_slot_next;
        idx_reg        <= idx_next;
        base_reg       <= base_next;
        q_reg          <= q_next;
        sq_reg         <= sq_next;
        acc_reg        <= acc_next;
        m_status_reg   <= m_status_next;
        m_key_reg      <= m_key_next;
        m_dist_reg     <= m_dist_next;
        m_elem_reg     <= m_elem_next;
        m_last_reg     <= m_last_next;
    end

`ifndef SYNTH
    a_accept_needs_empty_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid_reg)
        else $error("request accepted while a result is pending");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(fill_reg) <= CMP_W'(MAX_K))
        else $error("hit count above MAX_K");

    a_insert_fills_head: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins |=> cvld[0])
        else $error("insert left the head cell empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(MAX_DIM + 1))
        else $error("element count out of range");
`endif
endmodule

// ===== dv/brute_force_knn_index_chk.sv =====
module brute_force_knn_index_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    import bfknn_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    rkey;
        logic [DIST_W-1:0]   rdist;
        logic [15:0]         elem;
        logic                last;
    } knn_result_t;

    knn_result_t       result_q[$];
    logic [31:0]       key_mem[256];
    logic              slot_used[256];
    logic signed [15:0] vec_mem[256][16];
    logic signed [15:0] query_buf[16];
    int                gathered;
    int                dim;

    function automatic void push_result(logic [2:0] st, logic [31:0] k, logic [35:0] d,
                                        logic [15:0] e, logic l);
        knn_result_t r;
        r.status = st; r.rkey = k; r.rdist = d; r.elem = e; r.last = l;
        result_q.push_back(r);
    endfunction

    function automatic int slot_of(logic [31:0] k);
        for (int s = 0; s < 256; s++) if (slot_used[s] && key_mem[s] == k) return s;
        return -1;
    endfunction

    function automatic void apply_request(logic [1:0] op, logic [31:0] k,
                                          logic signed [15:0] e, logic last, int topk);
        int s, n, tk, cnt, pos, stop;
        bit dim_ok;
        longint d, diff;
        longint best_d[16];
        int best_s[16];
        dim_ok = dim >= 1 && dim <= 16;
        if (op == OP_REMOVE || op == OP_GET) begin
            gathered = 0;
            s = slot_of(k);
            if (s < 0) push_result(STAT_NOT_FOUND, 0, 0, 0, 1);
            else if (op == OP_REMOVE) begin
                slot_used[s] = 0;
                push_result(STAT_OK, 0, 0, 0, 1);
            end else if (!dim_ok) push_result(STAT_LEN_ERR, 0, 0, 0, 1);
            else for (int i = 0; i < dim; i++)
                push_result(STAT_OK, 0, 0, vec_mem[s][i], i + 1 == dim);
            return;
        end
        if (gathered < 16) query_buf[gathered] = e;
        if (gathered <= 16) gathered++;
        if (!last) return;
        n = gathered;
        gathered = 0;
        if (!dim_ok || n != dim) begin
            push_result(STAT_LEN_ERR, 0, 0, 0, 1);
            return;
        end
        if (op == OP_ADD) begin
            if (slot_of(k) >= 0) begin
                push_result(STAT_KEY_EXIST, 0, 0, 0, 1);
                return;
            end
            for (s = 0; s < 256; s++) if (!slot_used[s]) break;
            if (s >= 256) begin
                push_result(STAT_FULL, 0, 0, 0, 1);
                return;
            end
            key_mem[s] = k;
            slot_used[s] = 1;
            for (int i = 0; i < 16; i++) vec_mem[s][i] = i < n ? query_buf[i] : 16'sd0;
            push_result(STAT_OK, 0, 0, 0, 1);
            return;
        end
        tk = topk > 16 ? 16 : topk;
        cnt = 0;
        for (s = 0; s < 256; s++) begin
            if (!slot_used[s]) continue;
            d = 0;
            for (int i = 0; i < n; i++) begin
                diff = longint'(query_buf[i]) - longint'(vec_mem[s][i]);
                d += diff * diff;
            end
            pos = cnt;
            while (pos > 0 && best_d[pos-1] > d) pos--;
            if (pos >= tk) continue;
            stop = cnt < tk ? cnt : tk - 1;
            for (int j = stop; j > pos; j--) begin
                best_d[j] = best_d[j-1];
                best_s[j] = best_s[j-1];
            end
            best_d[pos] = d;
            best_s[pos] = s;
            if (cnt < tk) cnt++;
        end
        if (cnt == 0) push_result(STAT_NO_RESULT, 0, 0, 0, 1);
        else for (int i = 0; i < cnt; i++)
            push_result(STAT_OK, key_mem[best_s[i]], best_d[i][35:0], 0, i + 1 == cnt);
    endfunction

    always @(posedge aclk) begin
        knn_result_t got, want;
        if (!aresetn) begin
            result_q.delete();
            foreach (slot_used[i]) slot_used[i] = 0;
            gathered = 0;
            dim = 16;
            errors <= 0;
        end else begin
            if (cfg_we) dim = cfg_wdata;
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tlast, s_tdata[52:48]);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[2:0], m_tdata[34:3], m_tdata[70:35], m_tdata[86:71], m_tlast};
                if (result_q.size() == 0) begin
                    $error("unexpected result %h", got);
                    errors <= errors + 1;
                end else begin
                    want = result_q.pop_front();
                    if (got.status !== want.status)
                        $error("status exp %0d got %0d", want.status, got.status);
                    if (got.rkey !== want.rkey)
                        $error("result_key exp %h got %h", want.rkey, got.rkey);
                    if (got.rdist !== want.rdist)
                        $error("distance exp %0d got %0d", want.rdist, got.rdist);
                    if (got.elem !== want.elem)
                        $error("result_element exp %h got %h", want.elem, got.elem);
                    if (got.last !== want.last)
                        $error("last_result exp %0d got %0d", want.last, got.last);
                    if (got !== want) errors <= errors + 1;
                end
            end
        end
        pending <= result_q.size();
    end
endmodule

// ===== dv/tb.sv =====
module tb;
    import bfknn_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    logic        m_tlast;
    int          errors, pending;
    int          cycles = 0;
    bit          hold_off = 0;

    always #5 aclk = ~aclk;

    brute_force_knn_index_top dut (.*);
    brute_force_knn_index_chk chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 4000000) begin
            $display("brute_force_knn_index_top test failed");
            $finish;
        end
    end

    // result side
    initial begin
        int n;
        repeat (5) @(posedge aclk);
        m_tready <= 1;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
                if (hold_off) begin
                    n = 3000;
                    hold_off = 0;
                end
                if (n > 0) begin
                    m_tready <= 0;
                    repeat (n) @(posedge aclk);
                    m_tready <= 1;
                end
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [31:0] k, logic [15:0] e,
                                logic last, logic [4:0] topk, bit busy = 0);
        int n;
        n = (busy || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
        if (n > 0) begin
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {3'b0, topk, e, k};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_vector(logic [1:0] op, logic [31:0] k, int len, logic [4:0] topk,
                               bit same = 0, logic [15:0] fill = 0);
        for (int i = 0; i < len; i++)
            send_request(op, k, same ? fill : rand_elem(), i == len - 1, topk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_dimension(logic [4:0] v);
        drain();
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    logic [4:0] dims[4] = '{5'd16, 5'd4, 5'd1, 5'd7};

    initial begin
        int cur, len, pick;
        logic [31:0] k;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        send_vector(OP_SEARCH, 0, 16, 5'd4);
        send_request(OP_GET, 32'h1234, 0, 1, 0);
        send_request(OP_REMOVE, 32'h1234, 0, 1, 0);
        send_vector(OP_ADD, 32'hffffffff, 16, 0, 1, 16'h7fff);
        send_vector(OP_ADD, 0, 16, 0, 1, 16'h8000);
        send_vector(OP_ADD, 0, 16, 0);
        send_vector(OP_ADD, 32'h55, 16, 0, 1, 16'h7fff);
        send_request(OP_GET, 0, 0, 1, 0);
        send_vector(OP_SEARCH, 0, 16, 5'd0);
        send_vector(OP_SEARCH, 0, 16, 5'd31, 1, 16'h8000);
        send_vector(OP_ADD, 9, 3, 0);
        send_vector(OP_ADD, 9, 18, 0);
        send_vector(OP_ADD, 9, 7, 0);
        send_request(OP_REMOVE, 32'h55, 0, 0, 0);
        send_request(OP_GET, 32'hffffffff, 0, 0, 5'd31);
        set_dimension(0);
        send_vector(OP_ADD, 7, 1, 0);
        send_request(OP_GET, 0, 0, 1, 0);
        set_dimension(31);
        send_vector(OP_SEARCH, 7, 16, 5'd2);
        set_dimension(4);
        send_vector(OP_ADD, 5, 4, 0);
        set_dimension(16);
        send_request(OP_GET, 5, 0, 1, 0);
        send_vector(OP_SEARCH, 0, 16, 5'd16);

        // long receiver stall while requests keep coming
        hold_off = 1;
        for (int i = 0; i < 20; i++) send_request(OP_REMOVE, i, 0, 1, 0, 1);

        for (int ph = 0; ph < 4; ph++) begin
            set_dimension(dims[ph]);
            cur = dims[ph];
            for (int i = 0; i < 4; i++) begin
                k = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 15);
                pick = $urandom_range(0, 9);
                len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 18) : cur;
                if (pick < 4) send_vector(OP_ADD, k, len, 5'($urandom()));
                else if (pick < 6) send_vector(OP_SEARCH, k, len, 5'($urandom()));
                else if (pick < 7)
                    send_request(OP_REMOVE, k, 16'($urandom()), 1'($urandom()),
                                 5'($urandom()));
                else if (pick < 8)
                    send_request(OP_GET, k, 16'($urandom()), 1'($urandom()),
                                 5'($urandom()));
                else if (pick < 9) begin
                    send_vector(OP_ADD, k, $urandom_range(1, cur), 0, 1, rand_elem());
                    send_vector(OP_SEARCH, k, len, 5'($urandom_range(1, 16)));
                end else begin
                    for (int j = 0; j < $urandom_range(1, 3); j++)
                        send_request($urandom_range(0, 1) ? OP_ADD : OP_SEARCH, k,
                                     rand_elem(), 0, 5'($urandom()));
                    send_request(OP_GET, k, 0, 0, 0);
                end
                if (i == 1) drain();
            end
        end

        drain();
        if (errors == 0)
            $display("brute_force_knn_index_top test passed");
        else
            $display("brute_force_knn_index_top test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/bfknn_pkg.sv
rtl/bfknn_ram.sv
rtl/bfknn_cell.sv
rtl/brute_force_knn_index_top.sv
dv/brute_force_knn_index_chk.sv
dv/tb.sv
